### src/mpwm_pkg.sv
// ----------------------------------------------------------------------------
// mpwm_pkg
// Shared types and constants for the multichannel pwm register device:
// request kinds, register map and stream packing widths.
// ----------------------------------------------------------------------------
package mpwm_pkg;

    // request kind carried in s_tuser
    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_READ  = 2'd1,
        REQ_TICK  = 2'd2
    } req_type_t;

    // register map
    localparam logic [7:0] ADDR_MODE1    = 8'h00;
    localparam logic [7:0] ADDR_MODE2    = 8'h01;
    localparam logic [7:0] ADDR_CHAN0    = 8'h06;
    localparam logic [7:0] ADDR_PRESCALE = 8'hFE;

    // byte positions inside one channel's group of four
    localparam logic [1:0] BYTE_ON_L  = 2'd0;
    localparam logic [1:0] BYTE_ON_H  = 2'd1;
    localparam logic [1:0] BYTE_OFF_L = 2'd2;
    localparam logic [1:0] BYTE_OFF_H = 2'd3;

    localparam int SLEEP_BIT = 4;   // in mode1
    localparam int FULL_BIT  = 4;   // in ON_H and OFF_H

    localparam logic [7:0] MODE1_RESET    = 8'h11;
    localparam logic [7:0] MODE2_RESET    = 8'h04;
    localparam logic [7:0] PRESCALE_RESET = 8'd30;
    localparam logic [7:0] OFF_H_RESET    = 8'h10;

    // field widths
    localparam int REQ_W    = 2;
    localparam int ADDR_W   = 8;
    localparam int BYTE_W   = 8;
    localparam int TIME_W   = 12;
    localparam int PWM_W    = 16;
    localparam int COUNT_W  = 12;
    localparam int MAX_CH   = 16;

    // stream packing
    localparam int IN_TDATA_W  = 16;   // reg_addr, wr_data
    localparam int IN_TUSER_W  = 2;    // req_type
    localparam int OUT_TDATA_W = 40;   // rd_data, pwm_out, count_now, pad
    localparam int OUT_TUSER_W = 1;    // rd_valid

endpackage

### src/multichannel_pwm_register_device.sv
// ----------------------------------------------------------------------------
// multichannel_pwm_register_device
// Register model of a sixteen channel 12-bit pwm controller: byte register
// writes and reads, and oscillator ticks that drive a shared pwm counter.
// ----------------------------------------------------------------------------
// registers: an item goes from the input register through the state update,
//   which is stored together with the result in the result register
// throughput: one item per cycle while m_tready is high; the state update and
//   all channel compares sit in one combinational stage between the two
//   registers
// reset: rst_n async low clears both stages and loads the register reset
//   values (mode1 0x11, mode2 0x04, prescale 30, full-off set on every channel)

module multichannel_pwm_register_device #(
    parameter int NUM_CHANNELS = 16,
    parameter int COUNTER_BITS = 12
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // slave side
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [mpwm_pkg::IN_TDATA_W-1:0]   s_tdata,   // [7:0] reg_addr, [15:8] wr_data
    input  logic [mpwm_pkg::IN_TUSER_W-1:0]   s_tuser,   // [1:0] req_type
    // master side
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [mpwm_pkg::OUT_TDATA_W-1:0]  m_tdata,   // [7:0] rd_data, [23:8] pwm_out,
                                                         // [35:24] count_now, [39:36] zero
    output logic [mpwm_pkg::OUT_TUSER_W-1:0]  m_tuser    // [0] rd_valid
);

    import mpwm_pkg::*;

    localparam logic [8:0] CHAN_BYTES = 9'(4 * NUM_CHANNELS);

    // input stage
    logic                  in_valid_reg;
    req_type_t             in_type_reg;
    logic [ADDR_W-1:0]     in_addr_reg;
    logic [BYTE_W-1:0]     in_data_reg;

    // register file and counters
    logic [BYTE_W-1:0]       mode1_reg,    mode1_next;
    logic [BYTE_W-1:0]       mode2_reg,    mode2_next;
    logic [BYTE_W-1:0]       prescale_reg, prescale_next;
    logic [BYTE_W-1:0]       div_reg,      div_next;
    logic [COUNTER_BITS-1:0] cnt_reg,      cnt_next;
    logic [BYTE_W-1:0]       chan_reg  [NUM_CHANNELS][4];
    logic [BYTE_W-1:0]       chan_next [NUM_CHANNELS][4];

    // result stage
    logic                  out_valid_reg;
    logic [BYTE_W-1:0]     out_rd_data_reg, rd_data_next;
    logic                  out_rd_valid_reg, rd_valid_next;
    logic [PWM_W-1:0]      out_pwm_reg, pwm_next;
    logic [COUNT_W-1:0]    out_count_reg;

    logic                  out_load;
    logic                  advance;

    logic [ADDR_W-1:0]     chan_idx;
    logic                  chan_hit;
    logic [5:0]            chan_sel;
    logic [1:0]            byte_sel;

    assign out_load = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_load;
    assign s_tready = !in_valid_reg || out_load;

    assign chan_idx = in_addr_reg - ADDR_CHAN0;
    assign chan_hit = (in_addr_reg >= ADDR_CHAN0) && ({1'b0, chan_idx} < CHAN_BYTES);
    assign chan_sel = chan_idx[7:2];
    assign byte_sel = chan_idx[1:0];

    // state update and result for the item in the input stage
    always_comb
    begin
        logic [TIME_W-1:0]       on_t;
        logic [TIME_W-1:0]       off_t;
        logic                    f_on;
        logic                    f_off;
        logic [COUNTER_BITS-1:0] pos;
        logic [COUNTER_BITS-1:0] width;

        mode1_next    = mode1_reg;
        mode2_next    = mode2_reg;
        prescale_next = prescale_reg;
        div_next      = div_reg;
        cnt_next      = cnt_reg;
        chan_next     = chan_reg;
        rd_data_next  = '0;
        rd_valid_next = 1'b0;
        pwm_next      = '0;

        case (in_type_reg)
            REQ_WRITE:
            begin
                if (in_addr_reg == ADDR_MODE1)
                    mode1_next = in_data_reg;
                else if (in_addr_reg == ADDR_MODE2)
                    mode2_next = in_data_reg;
                else if (in_addr_reg == ADDR_PRESCALE)
                begin
                    // prescale only takes a write while asleep
                    if (mode1_reg[SLEEP_BIT])
                        prescale_next = in_data_reg;
                end
                else if (chan_hit)
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                        for (int k = 0; k < 4; k++)
                            if (chan_sel == 6'(i) && byte_sel == 2'(k))
                                chan_next[i][k] = in_data_reg;
                end
            end
            REQ_READ:
            begin
                rd_valid_next = 1'b1;
                if (in_addr_reg == ADDR_MODE1)
                    rd_data_next = mode1_reg;
                else if (in_addr_reg == ADDR_MODE2)
                    rd_data_next = mode2_reg;
                else if (in_addr_reg == ADDR_PRESCALE)
                    rd_data_next = prescale_reg;
                else if (chan_hit)
                begin
                    for (int i = 0; i < NUM_CHANNELS; i++)
                        for (int k = 0; k < 4; k++)
                            if (chan_sel == 6'(i) && byte_sel == 2'(k))
                                rd_data_next = chan_reg[i][k];
                end
            end
            REQ_TICK:
            begin
                if (!mode1_reg[SLEEP_BIT])
                begin
                    // divider at or past prescale wraps and steps the counter
                    if (div_reg >= prescale_reg)
                    begin
                        div_next = '0;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    else
                    begin
                        div_next = div_reg + 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // channel levels from the updated state
        for (int i = 0; i < NUM_CHANNELS; i++)
        begin
            on_t  = {chan_next[i][BYTE_ON_H][3:0],  chan_next[i][BYTE_ON_L]};
            off_t = {chan_next[i][BYTE_OFF_H][3:0], chan_next[i][BYTE_OFF_L]};
            f_on  = chan_next[i][BYTE_ON_H][FULL_BIT];
            f_off = chan_next[i][BYTE_OFF_H][FULL_BIT];
            pos   = cnt_next - COUNTER_BITS'(on_t);
            width = COUNTER_BITS'(off_t) - COUNTER_BITS'(on_t);
            if (f_on && !f_off)
                pwm_next[i] = 1'b1;
            else if (f_off && !f_on)
                pwm_next[i] = 1'b0;
            else
                pwm_next[i] = (pos < width);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode1_reg     <= MODE1_RESET;
            mode2_reg     <= MODE2_RESET;
            prescale_reg  <= PRESCALE_RESET;
            div_reg       <= '0;
            cnt_reg       <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++)
            begin
                chan_reg[i][BYTE_ON_L]  <= '0;
                chan_reg[i][BYTE_ON_H]  <= '0;
                chan_reg[i][BYTE_OFF_L] <= '0;
                chan_reg[i][BYTE_OFF_H] <= OFF_H_RESET;
            end
        end
        else
        begin
            if (s_tvalid && s_tready)
                in_valid_reg <= 1'b1;
            else if (advance)
                in_valid_reg <= 1'b0;

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            if (advance)
            begin
                mode1_reg    <= mode1_next;
                mode2_reg    <= mode2_next;
                prescale_reg <= prescale_next;
                div_reg      <= div_next;
                cnt_reg      <= cnt_next;
                chan_reg     <= chan_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_type_reg <= req_type_t'(s_tuser);
            in_addr_reg <= s_tdata[7:0];
            in_data_reg <= s_tdata[15:8];
        end
        if (advance)
        begin
            out_rd_data_reg  <= rd_data_next;
            out_rd_valid_reg <= rd_valid_next;
            out_pwm_reg      <= pwm_next;
            out_count_reg    <= COUNT_W'(cnt_next);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, out_count_reg, out_pwm_reg, out_rd_data_reg};
    assign m_tuser  = out_rd_valid_reg;

    // a non-read result never carries read data
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_rd_valid_reg |-> out_rd_data_reg == '0)
        else $error("read data on a non-read result");

    // while asleep the pwm counter holds
    assert property (@(posedge clk) disable iff (!rst_n)
        mode1_reg[SLEEP_BIT] |=> $stable(cnt_reg))
        else $error("pwm counter moved during sleep");

    // an item leaving the input stage shows up as a result
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("item lost between input and result stage");

    // channels above the configured count stay low
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_pwm_reg >> NUM_CHANNELS) == '0)
        else $error("unused channel driven high");

endmodule
